// ===== hdl/ctp_pkg.sv =====
package ctp_pkg;

    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned ACC_W    = 7;
    localparam int unsigned POS_W    = 4;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [POS_W-1:0] TS_LENGTH  = 4'd14;
    localparam logic [POS_W-1:0] POS_YEAR_LO = 4'd2;
    localparam logic [POS_W-1:0] POS_MONTH  = 4'd4;
    localparam logic [POS_W-1:0] POS_DAY    = 4'd6;
    localparam logic [POS_W-1:0] POS_HOUR   = 4'd8;
    localparam logic [POS_W-1:0] POS_MINUTE = 4'd10;
    localparam logic [POS_W-1:0] POS_SECOND = 4'd12;

    localparam logic [YEAR_W-1:0] YEAR_LOWEST_RST  = 14'd1970;
    localparam logic [YEAR_W-1:0] YEAR_HIGHEST_RST = 14'd2100;

    localparam logic [ACC_W-1:0] MONTHS_PER_YEAR = 7'd12;
    localparam logic [ACC_W-1:0] HOURS_PER_DAY   = 7'd24;
    localparam logic [ACC_W-1:0] MINUTES_PER_HR  = 7'd60;
    localparam logic [ACC_W-1:0] SECONDS_PER_MIN = 7'd60;
    localparam logic [ACC_W-1:0] MONTH_FEB       = 7'd2;
    localparam logic [ACC_W-1:0] MONTH_APR       = 7'd4;
    localparam logic [ACC_W-1:0] MONTH_JUN       = 7'd6;
    localparam logic [ACC_W-1:0] MONTH_SEP       = 7'd9;
    localparam logic [ACC_W-1:0] MONTH_NOV       = 7'd11;
    localparam logic [ACC_W-1:0] DAYS_LONG       = 7'd31;
    localparam logic [ACC_W-1:0] DAYS_SHORT      = 7'd30;
    localparam logic [ACC_W-1:0] DAYS_FEB_LEAP   = 7'd29;
    localparam logic [ACC_W-1:0] DAYS_FEB        = 7'd28;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_YEAR_LOWEST  = 2'd0,
        CFG_YEAR_HIGHEST = 2'd1
    } cfg_index_t;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_LENGTH = 2'd1,
        STATUS_DIGIT  = 2'd2,
        STATUS_RANGE  = 2'd3
    } status_t;

    // Finished string handed from the parser to the checker
    typedef struct packed {
        logic              length_bad;
        logic              bad_digit;
        logic [YEAR_W-1:0] year;
        logic [ACC_W-1:0]  year_hi;
        logic [ACC_W-1:0]  year_lo;
        logic [ACC_W-1:0]  month;
        logic [ACC_W-1:0]  day;
        logic [ACC_W-1:0]  hour;
        logic [ACC_W-1:0]  minute;
        logic [ACC_W-1:0]  second;
    } snap_t;

    function automatic logic [ACC_W-1:0] acc7_next(input logic [ACC_W-1:0] acc,
                                                   input logic [3:0] digit);
        logic [ACC_W+3:0] wide;
        wide = ((ACC_W+4)'(acc) << 3) + ((ACC_W+4)'(acc) << 1) + (ACC_W+4)'(digit);
        return wide[ACC_W-1:0];
    endfunction

    function automatic logic [YEAR_W-1:0] acc14_next(input logic [YEAR_W-1:0] acc,
                                                     input logic [3:0] digit);
        logic [YEAR_W+3:0] wide;
        wide = ((YEAR_W+4)'(acc) << 3) + ((YEAR_W+4)'(acc) << 1) + (YEAR_W+4)'(digit);
        return wide[YEAR_W-1:0];
    endfunction

endpackage

// ===== hdl/compact_timestamp_parse_validate.sv =====
// Pipeline: two register stages, the finished-string register and the result register,
// which the result of a string passes through after its final item is accepted.
// Throughput: one character item per cycle if in_ready; parse state updates in one step.
// The result register and the finished-string register each hold one string, so input
// stalls only when both are full and out_ready is low.
// Reset (rst_n low, asynchronous): parse state cleared, no result pending,
// year limits return to 1970 and 2100.
module compact_timestamp_parse_validate (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     character,
    input  logic                           final_char,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     status,
    output logic [ctp_pkg::YEAR_W-1:0]     year,
    output logic [3:0]                     month,
    output logic [4:0]                     day,
    output logic [4:0]                     hour,
    output logic [5:0]                     minute,
    output logic [5:0]                     second,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ctp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ctp_pkg::YEAR_W-1:0]     cfg_data
);
    import ctp_pkg::*;

    logic [YEAR_W-1:0] year_lowest_reg;
    logic [YEAR_W-1:0] year_highest_reg;
    logic              take;
    logic              res_free;
    logic              snap_valid;
    snap_t             snap;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_lowest_reg  <= YEAR_LOWEST_RST;
            year_highest_reg <= YEAR_HIGHEST_RST;
        end
        else if (cfg_valid)
        begin
            // unknown indexes drop the write
            case (cfg_index)
                CFG_YEAR_LOWEST:  year_lowest_reg  <= cfg_data;
                CFG_YEAR_HIGHEST: year_highest_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign in_ready = !snap_valid || res_free;
    assign take     = in_valid && in_ready;

    ctp_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .character  (character),
        .final_char (final_char),
        .advance    (res_free),
        .snap_valid (snap_valid),
        .snap       (snap)
    );

    ctp_check u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .snap_valid   (snap_valid),
        .snap         (snap),
        .year_lowest  (year_lowest_reg),
        .year_highest (year_highest_reg),
        .out_ready    (out_ready),
        .res_free     (res_free),
        .out_valid    (out_valid),
        .status       (status),
        .year         (year),
        .month        (month),
        .day          (day),
        .hour         (hour),
        .minute       (minute),
        .second       (second)
    );

endmodule

// ===== hdl/ctp_parse.sv =====
module ctp_parse (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          take,
    input  logic [7:0]    character,
    input  logic          final_char,
    input  logic          advance,
    output logic          snap_valid,
    output ctp_pkg::snap_t snap
);
    import ctp_pkg::*;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              overlong_reg, overlong_next;
    logic              bad_reg, bad_next;
    logic [YEAR_W-1:0] year_reg, year_next;
    logic [ACC_W-1:0]  year_hi_reg, year_hi_next;
    logic [ACC_W-1:0]  year_lo_reg, year_lo_next;
    logic [ACC_W-1:0]  month_reg, month_next;
    logic [ACC_W-1:0]  day_reg, day_next;
    logic [ACC_W-1:0]  hour_reg, hour_next;
    logic [ACC_W-1:0]  minute_reg, minute_next;
    logic [ACC_W-1:0]  second_reg, second_next;
    logic              snap_valid_reg, snap_valid_next;
    snap_t             snap_reg, snap_next;
    logic              is_digit;
    logic [3:0]        digit;

    assign is_digit = character inside {[8'h30:8'h39]};
    assign digit    = character[3:0];

    always_comb
    begin
        pos_next      = pos_reg;
        overlong_next = overlong_reg;
        bad_next      = bad_reg;
        year_next     = year_reg;
        year_hi_next  = year_hi_reg;
        year_lo_next  = year_lo_reg;
        month_next    = month_reg;
        day_next      = day_reg;
        hour_next     = hour_reg;
        minute_next   = minute_reg;
        second_next   = second_reg;
        if (pos_reg >= TS_LENGTH)
        begin
            // past the end: only note the excess
            overlong_next = 1'b1;
        end
        else
        begin
            pos_next = pos_reg + 4'd1;
            if (!is_digit)
            begin
                bad_next = 1'b1;
            end
            else if (pos_reg < POS_MONTH)
            begin
                year_next = acc14_next(year_reg, digit);
                if (pos_reg < POS_YEAR_LO)
                    year_hi_next = acc7_next(year_hi_reg, digit);
                else
                    year_lo_next = acc7_next(year_lo_reg, digit);
            end
            else if (pos_reg < POS_DAY)
                month_next = acc7_next(month_reg, digit);
            else if (pos_reg < POS_HOUR)
                day_next = acc7_next(day_reg, digit);
            else if (pos_reg < POS_MINUTE)
                hour_next = acc7_next(hour_reg, digit);
            else if (pos_reg < POS_SECOND)
                minute_next = acc7_next(minute_reg, digit);
            else
                second_next = acc7_next(second_reg, digit);
        end
    end

    always_comb
    begin
        snap_next.length_bad = overlong_next || (pos_next != TS_LENGTH);
        snap_next.bad_digit  = bad_next;
        snap_next.year       = year_next;
        snap_next.year_hi    = year_hi_next;
        snap_next.year_lo    = year_lo_next;
        snap_next.month      = month_next;
        snap_next.day        = day_next;
        snap_next.hour       = hour_next;
        snap_next.minute     = minute_next;
        snap_next.second     = second_next;

        if (take && final_char)
            snap_valid_next = 1'b1;
        else if (advance)
            snap_valid_next = 1'b0;
        else
            snap_valid_next = snap_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            overlong_reg   <= 1'b0;
            bad_reg        <= 1'b0;
            year_reg       <= '0;
            year_hi_reg    <= '0;
            year_lo_reg    <= '0;
            month_reg      <= '0;
            day_reg        <= '0;
            hour_reg       <= '0;
            minute_reg     <= '0;
            second_reg     <= '0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            snap_valid_reg <= snap_valid_next;
            if (take)
            begin
                if (final_char)
                begin
                    // string done: start over for the next one
                    pos_reg      <= '0;
                    overlong_reg <= 1'b0;
                    bad_reg      <= 1'b0;
                    year_reg     <= '0;
                    year_hi_reg  <= '0;
                    year_lo_reg  <= '0;
                    month_reg    <= '0;
                    day_reg      <= '0;
                    hour_reg     <= '0;
                    minute_reg   <= '0;
                    second_reg   <= '0;
                end
                else
                begin
                    pos_reg      <= pos_next;
                    overlong_reg <= overlong_next;
                    bad_reg      <= bad_next;
                    year_reg     <= year_next;
                    year_hi_reg  <= year_hi_next;
                    year_lo_reg  <= year_lo_next;
                    month_reg    <= month_next;
                    day_reg      <= day_next;
                    hour_reg     <= hour_next;
                    minute_reg   <= minute_next;
                    second_reg   <= second_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && final_char)
            snap_reg <= snap_next;
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

// ===== hdl/ctp_check.sv =====
module ctp_check (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        snap_valid,
    input  ctp_pkg::snap_t              snap,
    input  logic [ctp_pkg::YEAR_W-1:0]  year_lowest,
    input  logic [ctp_pkg::YEAR_W-1:0]  year_highest,
    input  logic                        out_ready,
    output logic                        res_free,
    output logic                        out_valid,
    output logic [1:0]                  status,
    output logic [ctp_pkg::YEAR_W-1:0]  year,
    output logic [3:0]                  month,
    output logic [4:0]                  day,
    output logic [4:0]                  hour,
    output logic [5:0]                  minute,
    output logic [5:0]                  second
);
    import ctp_pkg::*;

    logic              leap;
    logic [ACC_W-1:0]  month_days;
    logic              range_bad;
    status_t           status_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        status_reg;
    logic [YEAR_W-1:0] year_reg;
    logic [3:0]        month_reg;
    logic [4:0]        day_reg;
    logic [4:0]        hour_reg;
    logic [5:0]        minute_reg;
    logic [5:0]        second_reg;
    logic              ok;

    // Century years are leap only when the century digits divide by four
    assign leap = (snap.year_lo != '0) ? (snap.year_lo[1:0] == 2'b00)
                                       : (snap.year_hi[1:0] == 2'b00);

    always_comb
    begin
        if (snap.month == MONTH_FEB)
            month_days = leap ? DAYS_FEB_LEAP : DAYS_FEB;
        else if (snap.month == MONTH_APR || snap.month == MONTH_JUN ||
                 snap.month == MONTH_SEP || snap.month == MONTH_NOV)
            month_days = DAYS_SHORT;
        else
            month_days = DAYS_LONG;

        range_bad = (snap.year < year_lowest) || (snap.year > year_highest) ||
                    (snap.month == '0) || (snap.month > MONTHS_PER_YEAR) ||
                    (snap.day == '0) || (snap.day > month_days) ||
                    (snap.hour >= HOURS_PER_DAY) ||
                    (snap.minute >= MINUTES_PER_HR) ||
                    (snap.second >= SECONDS_PER_MIN);

        if (snap.length_bad)
            status_next = STATUS_LENGTH;
        else if (snap.bad_digit)
            status_next = STATUS_DIGIT;
        else if (range_bad)
            status_next = STATUS_RANGE;
        else
            status_next = STATUS_OK;
    end

    assign ok       = (status_next == STATUS_OK);
    assign res_free = !out_valid_reg || out_ready;

    always_comb
    begin
        if (res_free)
            out_valid_next = snap_valid;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Fields read as zero unless the string passed every check
    always_ff @(posedge clk)
    begin
        if (res_free && snap_valid)
        begin
            status_reg <= status_next;
            year_reg   <= ok ? snap.year : '0;
            month_reg  <= ok ? snap.month[3:0] : '0;
            day_reg    <= ok ? snap.day[4:0] : '0;
            hour_reg   <= ok ? snap.hour[4:0] : '0;
            minute_reg <= ok ? snap.minute[5:0] : '0;
            second_reg <= ok ? snap.second[5:0] : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign year      = year_reg;
    assign month     = month_reg;
    assign day       = day_reg;
    assign hour      = hour_reg;
    assign minute    = minute_reg;
    assign second    = second_reg;

endmodule
